@@ sv/vwh_pkg.sv @@
// Shared types and constants for the vertex weld hash table.
// Holds field widths, status and register codes, and the sequencer states.
// No dependencies.
package vwh_pkg;

    localparam int COORD_W     = 21;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int OUT_IDX_W   = 12;
    localparam int STAT_W      = 2;
    localparam int SNAP_TOL_W  = 8;
    localparam int MATCH_TOL_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 16;
    localparam int CELL_W      = 7;
    localparam int GRID_OFFSET = 4096;
    localparam int GRID_SHIFT  = 7;
    localparam int SNAP_HALF   = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SNAP_TOL  = 1'b0,
        REG_MATCH_TOL = 1'b1
    } t_cfg_reg;

    typedef enum logic [STAT_W-1:0] {
        STAT_MATCH  = 2'd0,
        STAT_INSERT = 2'd1,
        STAT_GRID   = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SNAP,
        ST_GRID,
        ST_HEAD_RD,
        ST_HEAD,
        ST_FETCH,
        ST_CMP,
        ST_INSERT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic head_we;
        logic entry_we;
    } t_store_ctl;

endpackage

@@ sv/vwh_snap_unit.sv @@
// Shared snap unit: rounds one coordinate to an integer within tolerance,
// saturates, and derives its grid cell. Used once per coordinate in turn.
// Depends on vwh_pkg.
module vwh_snap_unit (
    input  logic signed [vwh_pkg::COORD_W-1:0]    i_coord,
    input  logic        [vwh_pkg::SNAP_TOL_W-1:0] i_snap_tol,
    output logic signed [vwh_pkg::COORD_W-1:0]    o_snapped,
    output logic        [vwh_pkg::CELL_W-1:0]     o_cell
);
    import vwh_pkg::*;

    logic signed [COORD_W:0]   v_ext;
    logic signed [COORD_W:0]   a;
    logic signed [COORD_W:0]   f;
    logic signed [COORD_W:0]   d;
    logic        [8:0]         ad;
    logic signed [COORD_W:0]   sv;
    logic signed [COORD_W:0]   a2;
    logic signed [COORD_W:0]   a2_adj;
    logic signed [14:0]        g;

    always_comb begin
        v_ext = {i_coord[COORD_W-1], i_coord};
        a     = v_ext + (COORD_W+1)'(SNAP_HALF);
        f     = {a[COORD_W:8], 8'd0};
        d     = v_ext - f;
        ad    = d[COORD_W] ? 9'(-d) : 9'(d);
        sv    = (ad < {1'b0, i_snap_tol}) ? f : v_ext;
        if (sv[COORD_W:COORD_W-1] == 2'b01) begin
            o_snapped = {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            o_snapped = sv[COORD_W-1:0];
        end
        a2     = {o_snapped[COORD_W-1], o_snapped} + (COORD_W+1)'(SNAP_HALF);
        a2_adj = a2[COORD_W] ? a2 + (COORD_W+1)'(255) : a2;
        g      = 15'(GRID_OFFSET) + 15'(a2_adj >>> 8);
        o_cell = g[GRID_SHIFT +: CELL_W];
    end

endmodule

@@ sv/vwh_match_unit.sv @@
// Compare unit: checks a stored vertex against the snapped point on all
// three axes against the match tolerance. Depends on vwh_pkg.
module vwh_match_unit (
    input  logic [vwh_pkg::POINT_W-1:0]     i_point,
    input  logic [vwh_pkg::POINT_W-1:0]     i_stored,
    input  logic [vwh_pkg::MATCH_TOL_W-1:0] i_match_tol,
    output logic                            o_match
);
    import vwh_pkg::*;

    logic signed [COORD_W:0] diff [3];
    logic        [COORD_W:0] mag  [3];
    logic        [2:0]       near;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {i_point[k*COORD_W + COORD_W-1], i_point[k*COORD_W +: COORD_W]}
                    - {i_stored[k*COORD_W + COORD_W-1], i_stored[k*COORD_W +: COORD_W]};
            mag[k]  = diff[k][COORD_W] ? (COORD_W+1)'(-diff[k]) : (COORD_W+1)'(diff[k]);
            near[k] = mag[k] < (COORD_W+1)'(i_match_tol);
        end
        o_match = &near;
    end

endmodule

@@ sv/vwh_store.sv @@
// Table storage: bucket head memory, chain link memory and vertex memory,
// each with a registered read port. Depends on vwh_pkg.
module vwh_store #(
    parameter int CAP     = 4096,
    parameter int BUCKETS = 4096,
    parameter int IW      = 12,
    parameter int BW      = 12
) (
    input  logic                         i_clk,
    input  vwh_pkg::t_store_ctl          i_ctl,
    input  logic [BW-1:0]                i_head_addr,
    input  logic [IW-1:0]                i_head_wdata,
    output logic [IW-1:0]                o_head_rdata,
    input  logic [IW-1:0]                i_entry_raddr,
    input  logic [IW-1:0]                i_entry_waddr,
    input  logic [IW-1:0]                i_link_wdata,
    input  logic [vwh_pkg::POINT_W-1:0]  i_point_wdata,
    output logic [IW-1:0]                o_link_rdata,
    output logic [vwh_pkg::POINT_W-1:0]  o_point_rdata
);
    import vwh_pkg::*;

    logic [IW-1:0]      head_mem  [BUCKETS];
    logic [IW-1:0]      link_mem  [CAP];
    logic [POINT_W-1:0] point_mem [CAP];

    always_ff @(posedge i_clk) begin
        if (i_ctl.head_we) begin
            head_mem[i_head_addr] <= i_head_wdata;
        end
        o_head_rdata <= head_mem[i_head_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.entry_we) begin
            link_mem[i_entry_waddr]  <= i_link_wdata;
            point_mem[i_entry_waddr] <= i_point_wdata;
        end
        o_link_rdata  <= link_mem[i_entry_raddr];
        o_point_rdata <= point_mem[i_entry_raddr];
    end

endmodule

@@ sv/vertex_weld_hash_table_unit.sv @@
// Vertex weld hash table: snaps a point, hashes it to a grid bucket, walks the bucket chain.
// Steps: snap each coordinate in turn, check the grid cell, read the bucket head, then walk the chain
// newest first to a match or to its end (insert); outside-grid points stop after the grid check.
// One item at a time: the input is ready only while idle, from the cycle after the result transfer.
// After reset a clearing pass writes GRID_SIDE*GRID_SIDE head entries, one per cycle,
// before the first input transfer; configuration writes are taken at any time.
module vertex_weld_hash_table_unit #(
    parameter int VERTEX_CAPACITY = 4096,
    parameter int GRID_SIDE       = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_coord [20:0], y_coord [41:21], z_coord [62:42], zero [63]
    input  logic [vwh_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // vertex_index [11:0], zero [15:12]
    output logic [vwh_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [vwh_pkg::STAT_W-1:0]          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vwh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vwh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vwh_pkg::*;

    localparam int BUCKETS = GRID_SIDE * GRID_SIDE;
    localparam int IW      = $clog2(VERTEX_CAPACITY);
    localparam int NW      = $clog2(VERTEX_CAPACITY + 1);
    localparam int BW      = $clog2(BUCKETS);
    localparam int XW      = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;

    t_state                      r_state, n_state;
    logic [1:0]                  r_cnt, n_cnt;
    logic signed [COORD_W-1:0]   r_in [3];
    logic signed [COORD_W-1:0]   n_in [3];
    logic signed [COORD_W-1:0]   r_pt [3];
    logic signed [COORD_W-1:0]   n_pt [3];
    logic [CELL_W-1:0]           r_cell_x, n_cell_x;
    logic [CELL_W-1:0]           r_cell_y, n_cell_y;
    logic [BW-1:0]               r_bucket, n_bucket;
    logic [BW-1:0]               r_clr, n_clr;
    logic [IW-1:0]               r_vnum, n_vnum;
    logic [IW-1:0]               r_head, n_head;
    logic [NW-1:0]               r_next_free, n_next_free;
    logic [IW-1:0]               r_out_index, n_out_index;
    t_status                     r_out_status, n_out_status;
    logic [SNAP_TOL_W-1:0]       r_snap_tol;
    logic [MATCH_TOL_W-1:0]      r_match_tol;

    logic signed [COORD_W-1:0]   snapped;
    logic [CELL_W-1:0]           grid_pos;
    logic                        match;
    logic [POINT_W-1:0]          point_packed;
    logic [IW-1:0]               head_rdata;
    logic [IW-1:0]               link_rdata;
    logic [POINT_W-1:0]          point_rdata;
    t_store_ctl                  store_ctl;
    logic [BW-1:0]               head_addr;
    logic [IW-1:0]               head_wdata;
    logic [XW-1:0]               out_index_ext;

    assign point_packed = {r_pt[2], r_pt[1], r_pt[0]};

    vwh_snap_unit u_snap (
        .i_coord    (r_in[r_cnt]),
        .i_snap_tol (r_snap_tol),
        .o_snapped  (snapped),
        .o_cell     (grid_pos)
    );

    vwh_match_unit u_match (
        .i_point     (point_packed),
        .i_stored    (point_rdata),
        .i_match_tol (r_match_tol),
        .o_match     (match)
    );

    vwh_store #(
        .CAP     (VERTEX_CAPACITY),
        .BUCKETS (BUCKETS),
        .IW      (IW),
        .BW      (BW)
    ) u_store (
        .i_clk         (i_clk),
        .i_ctl         (store_ctl),
        .i_head_addr   (head_addr),
        .i_head_wdata  (head_wdata),
        .o_head_rdata  (head_rdata),
        .i_entry_raddr (r_vnum),
        .i_entry_waddr (r_next_free[IW-1:0]),
        .i_link_wdata  (r_head),
        .i_point_wdata (point_packed),
        .o_link_rdata  (link_rdata),
        .o_point_rdata (point_rdata)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_tol  <= SNAP_TOL_W'(3);
            r_match_tol <= MATCH_TOL_W'(128);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SNAP_TOL:  r_snap_tol  <= i_cfg_data[SNAP_TOL_W-1:0];
                REG_MATCH_TOL: r_match_tol <= i_cfg_data[MATCH_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_next_free <= NW'(1);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_in         <= n_in;
        r_pt         <= n_pt;
        r_cell_x     <= n_cell_x;
        r_cell_y     <= n_cell_y;
        r_bucket     <= n_bucket;
        r_vnum       <= n_vnum;
        r_head       <= n_head;
        r_out_index  <= n_out_index;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_in          = r_in;
        n_pt          = r_pt;
        n_cell_x      = r_cell_x;
        n_cell_y      = r_cell_y;
        n_bucket      = r_bucket;
        n_clr         = r_clr;
        n_vnum        = r_vnum;
        n_head        = r_head;
        n_next_free   = r_next_free;
        n_out_index   = r_out_index;
        n_out_status  = r_out_status;
        store_ctl     = '0;
        head_addr     = r_bucket;
        head_wdata    = r_next_free[IW-1:0];
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                store_ctl.head_we = 1'b1;
                head_addr         = r_clr;
                head_wdata        = '0;
                n_clr             = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_in[0] = s_axis_tdata[0*COORD_W +: COORD_W];
                    n_in[1] = s_axis_tdata[1*COORD_W +: COORD_W];
                    n_in[2] = s_axis_tdata[2*COORD_W +: COORD_W];
                    n_cnt   = 2'd0;
                    n_state = ST_SNAP;
                end
            end
            ST_SNAP: begin
                n_pt[r_cnt] = snapped;
                if (r_cnt == 2'd0) begin
                    n_cell_x = grid_pos;
                end
                if (r_cnt == 2'd1) begin
                    n_cell_y = grid_pos;
                end
                if (r_cnt == 2'd2) begin
                    n_state = ST_GRID;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            ST_GRID: begin
                if ({2'b00, r_cell_x} >= 9'(GRID_SIDE) || {2'b00, r_cell_y} >= 9'(GRID_SIDE)) begin
                    n_out_index  = '0;
                    n_out_status = STAT_GRID;
                    n_state      = ST_OUT;
                end else begin
                    n_bucket = BW'(BW'(r_cell_y) * BW'(GRID_SIDE) + BW'(r_cell_x));
                    n_state  = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_head  = head_rdata;
                n_vnum  = head_rdata;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (r_vnum == '0) begin
                    n_state = ST_INSERT;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (match) begin
                    n_out_index  = r_vnum;
                    n_out_status = STAT_MATCH;
                    n_state      = ST_OUT;
                end else begin
                    n_vnum  = link_rdata;
                    n_state = ST_FETCH;
                end
            end
            ST_INSERT: begin
                if (r_next_free == NW'(VERTEX_CAPACITY)) begin
                    n_out_index  = '0;
                    n_out_status = STAT_FULL;
                end else begin
                    store_ctl.head_we  = 1'b1;
                    store_ctl.entry_we = 1'b1;
                    n_next_free        = r_next_free + NW'(1);
                    n_out_index        = r_next_free[IW-1:0];
                    n_out_status       = STAT_INSERT;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_index_ext = XW'(r_out_index);
    assign m_axis_tdata  = M_TDATA_W'(out_index_ext[OUT_IDX_W-1:0]);
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_next_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free != '0 && r_next_free <= NW'(VERTEX_CAPACITY))
        else $error("next free index out of range");

    a_insert_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT && r_next_free != NW'(VERTEX_CAPACITY))
        |=> r_next_free == $past(r_next_free) + NW'(1))
        else $error("insert did not advance the free index");

    a_error_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_status == STAT_GRID || r_out_status == STAT_FULL))
        |-> r_out_index == '0)
        else $error("error result carries a nonzero index");

    a_found_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_status == STAT_MATCH || r_out_status == STAT_INSERT))
        |-> r_out_index != '0)
        else $error("found or inserted vertex has the empty-chain index");
`endif

endmodule
